// File: sv/hngr_pkg.sv
// Package for the hashed n-gram id block: sizes, codes and shared types.
package hngr_pkg;

  localparam int NE_N        = 4;
  localparam int NE_K        = 4;
  localparam int HIST_DEPTH  = NE_N - 1;
  localparam int SLOT_DEPTH  = (NE_N - 1) * NE_K;
  localparam int WT_DEPTH    = SLOT_DEPTH * NE_N;
  localparam int SLOT_W      = $clog2(SLOT_DEPTH);
  localparam int WT_W        = $clog2(WT_DEPTH);
  localparam int HCNT_W      = $clog2(NE_N);
  localparam int J_W         = $clog2(NE_N + 1);
  localparam int N_W         = $clog2(NE_N);
  localparam int K_W         = $clog2(NE_K + 1);
  localparam int VAL_W       = 31;
  localparam int TOK_W       = 32;
  localparam int PROD_W      = 2 * VAL_W;
  localparam int CNT_W       = $clog2(PROD_W);
  localparam int CFG_W       = 4;
  localparam int QDEPTH      = 2;

  typedef enum logic [1:0] {
    REQ_WEIGHT  = 2'd0,
    REQ_MODULUS = 2'd1,
    REQ_OFFSET  = 2'd2,
    REQ_TOKEN   = 2'd3
  } req_t;

  typedef enum logic {
    REG_GRAMS  = 1'b0,
    REG_HASHES = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RDSLOT,
    B_SLOTDATA,
    B_TERM,
    B_MUL,
    B_DIV,
    B_ACC,
    B_RESULT
  } back_state_t;

  typedef struct packed {
    logic [TOK_W-1:0]                  tok;
    logic [HIST_DEPTH-1:0][TOK_W-1:0]  hist;
    logic [HCNT_W-1:0]                 hcount;
  } job_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [TOK_W-1:0]  id;
    logic              last;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [WT_W-1:0]  addr;
  } wt_wr_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
  } slot_wr_t;

endpackage

// File: sv/hngr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hngr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/hngr_queue.sv
// Short queue of token jobs between the front and back parts.
module hngr_queue
  import hngr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic empty
);

  localparam int PTR_W = $clog2(QDEPTH);

  job_t                   entries [QDEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [$clog2(QDEPTH+1)-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign full    = (count == ($clog2(QDEPTH+1))'(QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

// File: sv/hngr_front.sv
// Front part: accepts requests, writes tables, keeps the row history, queues token jobs.
module hngr_front
  import hngr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        req_type,
  input  logic [9:0]        table_index,
  input  logic [TOK_W-1:0]  token,
  input  logic              row_start,
  input  logic              emit_ids,
  input  logic [CFG_W-1:0]  cfg_g,
  input  logic [CFG_W-1:0]  cfg_h,
  input  logic              back_idle,
  input  logic              q_full,
  input  logic              q_empty,
  output logic              q_push,
  output job_t              q_din,
  output wt_wr_t            wt_wr,
  output slot_wr_t          mod_wr,
  output slot_wr_t          off_wr
);

  logic [HIST_DEPTH-1:0][TOK_W-1:0] hist;
  logic [HCNT_W-1:0]                hcount;
  logic [HCNT_W-1:0]                base_count;
  logic                             is_token;
  logic                             accept;
  req_t                             req;

  assign req        = req_t'(req_type);
  assign is_token   = (req == REQ_TOKEN);
  assign full       = is_token ? q_full : !(back_idle && q_empty);
  assign accept     = push && !full;
  assign base_count = row_start ? '0 : hcount;

  assign q_push       = accept && is_token && emit_ids && (cfg_g >= CFG_W'(2))
                        && (cfg_h != '0);
  assign q_din.tok    = token;
  assign q_din.hist   = hist;
  assign q_din.hcount = base_count;

  assign wt_wr.we   = accept && (req == REQ_WEIGHT) && (table_index < 10'(WT_DEPTH));
  assign wt_wr.addr = table_index[WT_W-1:0];
  assign mod_wr.we  = accept && (req == REQ_MODULUS) && (table_index < 10'(SLOT_DEPTH));
  assign mod_wr.addr = table_index[SLOT_W-1:0];
  assign off_wr.we  = accept && (req == REQ_OFFSET) && (table_index < 10'(SLOT_DEPTH));
  assign off_wr.addr = table_index[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      hist   <= '0;
      hcount <= '0;
    end else if (accept && is_token) begin
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
        hist[i] <= hist[i-1];
      end
      hist[0] <= token;
      if (base_count < HCNT_W'(HIST_DEPTH)) begin
        hcount <= base_count + 1'b1;
      end else begin
        hcount <= base_count;
      end
    end
  end

endmodule

// File: sv/hngr_back.sv
// Back part: works through the slots of one token job with a shared multiplier and remainder unit.
module hngr_back
  import hngr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [CFG_W-1:0]   cfg_g,
  input  logic [CFG_W-1:0]   cfg_h,
  input  logic               job_empty,
  input  job_t               job_in,
  output logic               job_pop,
  output logic               idle,
  output logic [SLOT_W-1:0]  slot_raddr,
  input  logic [VAL_W-1:0]   mod_rdata,
  input  logic [VAL_W-1:0]   off_rdata,
  output logic [WT_W-1:0]    wt_raddr,
  input  logic [VAL_W-1:0]   wt_rdata,
  input  logic               out_free,
  output logic               out_we,
  output res_t               out_res
);

  back_state_t       state;
  back_state_t       state_next;
  job_t              job;
  logic [SLOT_W-1:0] slot;
  logic [N_W-1:0]    n;
  logic [K_W-1:0]    k;
  logic [J_W-1:0]    j;
  logic [VAL_W-1:0]  mod_r;
  logic [VAL_W-1:0]  off_r;
  logic [VAL_W-1:0]  acc;
  logic [VAL_W-1:0]  rem;
  logic [VAL_W-1:0]  tcur;
  logic [PROD_W-1:0] prod;
  logic [CNT_W-1:0]  cnt;
  logic [CFG_W-1:0]  geff;
  logic [CFG_W-1:0]  heff;
  logic [TOK_W-1:0]  tsel;
  logic              tavail;
  logic              term_ok;
  logic              last_slot;
  logic [VAL_W:0]    rem_sh;
  logic [VAL_W:0]    acc_sum;

  assign geff = (cfg_g > CFG_W'(NE_N)) ? CFG_W'(NE_N) : cfg_g;
  assign heff = (cfg_h > CFG_W'(NE_K)) ? CFG_W'(NE_K) : cfg_h;
  assign last_slot = (CFG_W'(n) == geff - CFG_W'(2)) && (CFG_W'(k) == heff - CFG_W'(1));

  always_comb begin
    tsel   = job.tok;
    tavail = (j == '0);
    for (int i = 0; i < HIST_DEPTH; i++) begin
      if (j == J_W'(i + 1)) begin
        tsel   = job.hist[i];
        tavail = (HCNT_W'(i) < job.hcount);
      end
    end
  end

  assign term_ok = (j < J_W'(n) + J_W'(2)) && (mod_r != '0) && tavail && !tsel[TOK_W-1];
  assign rem_sh  = {rem, prod[PROD_W-1]};
  assign acc_sum = {1'b0, acc} + {1'b0, rem};

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:     if (!job_empty) state_next = B_RDSLOT;
      B_RDSLOT:   state_next = B_SLOTDATA;
      B_SLOTDATA: state_next = B_TERM;
      B_TERM:     state_next = term_ok ? B_MUL : B_RESULT;
      B_MUL:      state_next = B_DIV;
      B_DIV:      if (cnt == CNT_W'(PROD_W - 1)) state_next = B_ACC;
      B_ACC:      state_next = B_TERM;
      B_RESULT: begin
        if (out_free) begin
          state_next = last_slot ? B_IDLE : B_RDSLOT;
        end
      end
      default:    state_next = B_IDLE;
    endcase
  end

  always_comb begin
    job_pop      = (state == B_IDLE) && !job_empty;
    idle         = (state == B_IDLE);
    slot_raddr   = slot;
    wt_raddr     = WT_W'(slot) * WT_W'(NE_N) + WT_W'(j);
    out_we       = (state == B_RESULT) && out_free;
    out_res.slot = slot;
    out_res.id   = {1'b0, acc} + {1'b0, off_r};
    out_res.last = last_slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        job  <= job_in;
        slot <= '0;
        n    <= '0;
        k    <= '0;
      end
      B_RDSLOT: begin
        j <= '0;
      end
      B_SLOTDATA: begin
        mod_r <= mod_rdata;
        off_r <= off_rdata;
        acc   <= '0;
      end
      B_TERM: begin
        tcur <= tsel[VAL_W-1:0];
      end
      B_MUL: begin
        prod <= tcur * wt_rdata;
        rem  <= '0;
        cnt  <= '0;
      end
      B_DIV: begin
        rem  <= (rem_sh >= {1'b0, mod_r}) ? VAL_W'(rem_sh - {1'b0, mod_r}) : VAL_W'(rem_sh);
        prod <= {prod[PROD_W-2:0], 1'b0};
        cnt  <= cnt + 1'b1;
      end
      B_ACC: begin
        acc <= (acc_sum >= {1'b0, mod_r}) ? VAL_W'(acc_sum - {1'b0, mod_r})
                                          : VAL_W'(acc_sum);
        j   <= j + 1'b1;
      end
      B_RESULT: begin
        if (out_free) begin
          slot <= slot + 1'b1;
          if (CFG_W'(k) == heff - CFG_W'(1)) begin
            k <= '0;
            n <= n + 1'b1;
          end else begin
            k <= k + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/hashed_ngram_embedding_ids.sv
// Top level of the hashed n-gram id block: configuration port, tables and output register.
//
// Requests enter through push/full: table loads (weight, modulus, offset) and tokens.
// A token with emit_ids set yields one result per configuration slot, in ascending
// slot order, with last marking the final one; other requests yield nothing.
// Results leave through empty/pop from a one-entry output register.
// Each summed window token takes one 31 by 31 bit multiply and then a 62-step
// bit-serial remainder unit shared by all terms. Each slot first reads its modulus
// and offset, then sums its window tokens and presents its result; the back part
// takes each token's job from the queue before its first slot.
// A short job queue lets the front keep taking tokens while the back part works.
// Table loads wait until the back part and the queue are empty.
// Reset clears the row history, the queue and the output register, and sets
// gram_sizes_in_use and hashes_in_use to 4; table contents are undefined until loaded.
// When the receiver stalls, the back part holds its finished result and, once the
// queue fills, full rises; nothing is lost.
module hashed_ngram_embedding_ids
  import hngr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         req_type,
  input  logic [9:0]         table_index,
  input  logic [VAL_W-1:0]   table_value,
  input  logic signed [31:0] token,
  input  logic               row_start,
  input  logic               emit_ids,
  output logic               empty,
  input  logic               pop,
  output logic [5:0]         slot_index,
  output logic signed [31:0] ngram_id,
  output logic               last
);

  logic [CFG_W-1:0]  gram_sizes_in_use;
  logic [CFG_W-1:0]  hashes_in_use;
  reg_idx_t          reg_sel;
  logic              q_push;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  job_t              q_din;
  job_t              q_dout;
  wt_wr_t            wt_wr;
  slot_wr_t          mod_wr;
  slot_wr_t          off_wr;
  logic              back_idle;
  logic [SLOT_W-1:0] slot_raddr;
  logic [WT_W-1:0]   wt_raddr;
  logic [VAL_W-1:0]  mod_rdata;
  logic [VAL_W-1:0]  off_rdata;
  logic [VAL_W-1:0]  wt_rdata;
  logic              out_free;
  logic              out_we;
  res_t              res;
  res_t              out_reg;
  logic              out_valid;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (reg_sel)
      REG_GRAMS:  prdata = 32'(gram_sizes_in_use);
      REG_HASHES: prdata = 32'(hashes_in_use);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gram_sizes_in_use <= CFG_W'(4);
      hashes_in_use     <= CFG_W'(4);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_GRAMS:  gram_sizes_in_use <= pwdata[CFG_W-1:0];
        REG_HASHES: hashes_in_use     <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  hngr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .req_type    (req_type),
    .table_index (table_index),
    .token       (token),
    .row_start   (row_start),
    .emit_ids    (emit_ids),
    .cfg_g       (gram_sizes_in_use),
    .cfg_h       (hashes_in_use),
    .back_idle   (back_idle),
    .q_full      (q_full),
    .q_empty     (q_empty),
    .q_push      (q_push),
    .q_din       (q_din),
    .wt_wr       (wt_wr),
    .mod_wr      (mod_wr),
    .off_wr      (off_wr)
  );

  hngr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  hngr_ram #(.WIDTH(VAL_W), .DEPTH(WT_DEPTH)) u_wt_ram (
    .clk   (clk),
    .we    (wt_wr.we),
    .waddr (wt_wr.addr),
    .wdata (table_value),
    .raddr (wt_raddr),
    .rdata (wt_rdata)
  );

  hngr_ram #(.WIDTH(VAL_W), .DEPTH(SLOT_DEPTH)) u_mod_ram (
    .clk   (clk),
    .we    (mod_wr.we),
    .waddr (mod_wr.addr),
    .wdata (table_value),
    .raddr (slot_raddr),
    .rdata (mod_rdata)
  );

  hngr_ram #(.WIDTH(VAL_W), .DEPTH(SLOT_DEPTH)) u_off_ram (
    .clk   (clk),
    .we    (off_wr.we),
    .waddr (off_wr.addr),
    .wdata (table_value),
    .raddr (slot_raddr),
    .rdata (off_rdata)
  );

  hngr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_g      (gram_sizes_in_use),
    .cfg_h      (hashes_in_use),
    .job_empty  (q_empty),
    .job_in     (q_dout),
    .job_pop    (q_pop),
    .idle       (back_idle),
    .slot_raddr (slot_raddr),
    .mod_rdata  (mod_rdata),
    .off_rdata  (off_rdata),
    .wt_raddr   (wt_raddr),
    .wt_rdata   (wt_rdata),
    .out_free   (out_free),
    .out_we     (out_we),
    .out_res    (res)
  );

  assign out_free = !out_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_we) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_we) begin
      out_reg <= res;
    end
  end

  assign empty      = !out_valid;
  assign slot_index = 6'(out_reg.slot);
  assign ngram_id   = out_reg.id;
  assign last       = out_reg.last;

endmodule
